FILE: design/nl2_pkg.sv
// Package with shared types and constants of the minus-log2 Q16 pipeline.
`default_nettype none
package nl2_pkg;

  localparam int WidthA = 16;
  localparam int WidthR = 21;
  localparam int CoarseSteps = 4;
  localparam int FineSteps = 16;
  localparam int StepsPerStage = 4;
  localparam int FineStages = FineSteps / StepsPerStage;

  localparam int CoarseShift [CoarseSteps] = '{8, 4, 2, 1};

  localparam logic [WidthR-1:0] CoarseAdd [CoarseSteps] = '{
    21'h80000, 21'h40000, 21'h20000, 21'h10000
  };

  localparam logic [WidthR-1:0] FineAdd [FineSteps] = '{
    21'h095c0, 21'h0526a, 21'h02b80, 21'h01664,
    21'h00b5d, 21'h005ba, 21'h002e0, 21'h00171,
    21'h000b8, 21'h0005c, 21'h0002e, 21'h00017,
    21'h0000c, 21'h00006, 21'h00003, 21'h00001
  };

  typedef struct packed {
    logic [WidthA-1:0] a;
    logic [WidthR-1:0] r;
  } nl2_data_t;

endpackage
`default_nettype wire

FILE: design/nl2_fine_stage.sv
// One registered pipeline stage that performs four fine normalization steps.
`default_nettype none
module nl2_fine_stage #(
  parameter int K_FIRST = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire nl2_pkg::nl2_data_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output nl2_pkg::nl2_data_t     out_data
);

  logic               valid_r;
  nl2_pkg::nl2_data_t data_r;
  nl2_pkg::nl2_data_t data_nxt;

  always_comb begin
    logic [nl2_pkg::WidthA-1:0] a;
    logic [nl2_pkg::WidthR-1:0] r;
    logic [nl2_pkg::WidthA:0]   t;
    int                         k;
    a = in_data.a;
    r = in_data.r;
    for (int j = 0; j < nl2_pkg::StepsPerStage; j++) begin
      k = K_FIRST + j;
      t = {1'b0, a} + {1'b0, a >> k};
      if (!t[nl2_pkg::WidthA]) begin
        if (k < nl2_pkg::FineSteps) begin
          a = t[nl2_pkg::WidthA-1:0];
        end
        r = r + nl2_pkg::FineAdd[k-1];
      end
    end
    data_nxt.a = a;
    data_nxt.r = r;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/neg_log2_q16_unit.sv
// Top level: pipelined minus log2 of a 16-bit fraction, result in Q16.
// Throughput is one beat per cycle while out_tready is high; each of the five stages
// has its own valid bit and fills a bubble even while the output beat waits.
// Each fine step is one add-and-compare, with four steps per fine stage.
// Synchronous active-low reset clears all valid bits; data registers keep their value.
`default_nettype none
module neg_log2_q16_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [20:0] neg_log, [23:21] zero
);

  localparam int NLinks = nl2_pkg::FineStages + 1;

  logic               link_valid [NLinks];
  logic               link_ready [NLinks];
  nl2_pkg::nl2_data_t link_data  [NLinks];

  logic               s0_valid_r;
  nl2_pkg::nl2_data_t s0_data_r;
  nl2_pkg::nl2_data_t s0_data_nxt;
  logic [nl2_pkg::WidthR-1:0] neg_log;

  always_comb begin
    logic [nl2_pkg::WidthA-1:0] a;
    logic [nl2_pkg::WidthR-1:0] r;
    a = in_tdata;
    r = '0;
    for (int i = 0; i < nl2_pkg::CoarseSteps; i++) begin
      if ((a >> (nl2_pkg::WidthA - nl2_pkg::CoarseShift[i])) == '0) begin
        a = a << nl2_pkg::CoarseShift[i];
        r = r + nl2_pkg::CoarseAdd[i];
      end
    end
    s0_data_nxt.a = a;
    s0_data_nxt.r = r;
  end

  assign in_tready = !s0_valid_r || link_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_data_r <= s0_data_nxt;
    end
  end

  assign link_valid[0] = s0_valid_r;
  assign link_data[0]  = s0_data_r;

  for (genvar g = 0; g < nl2_pkg::FineStages; g++) begin : g_fine
    nl2_fine_stage #(
      .K_FIRST(1 + g * nl2_pkg::StepsPerStage)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (link_valid[g]),
      .in_ready (link_ready[g]),
      .in_data  (link_data[g]),
      .out_valid(link_valid[g+1]),
      .out_ready(link_ready[g+1]),
      .out_data (link_data[g+1])
    );
  end

  assign link_ready[NLinks-1] = out_tready;
  assign out_tvalid = link_valid[NLinks-1];
  assign neg_log = (link_data[NLinks-1].r == '0) ? nl2_pkg::WidthR'(1)
                                                 : link_data[NLinks-1].r;
  assign out_tdata = {3'b000, neg_log};

  a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    s0_valid_r |-> (s0_data_r.a[nl2_pkg::WidthA-1] || s0_data_r.a == '0))
    else $error("coarse stage left an unnormalized operand");

  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[20:0] != 21'd0 && out_tdata[23:21] == 3'b000))
    else $error("output beat carries zero or stray high bits");

  a_reset_clears: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> (!out_tvalid && !s0_valid_r))
    else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire

FILE: tb/tb_neg_log2_q16_unit.sv
// Self-checking testbench for the minus-log2 Q16 stream unit, with its own result predictor.
`default_nettype none
module tb_neg_log2_q16_unit;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  localparam logic [32:0] Q16_ONE = 33'h10000;
  localparam int MAX_PRINTED = 40;

  localparam logic [20:0] FINE_STEP_ADD [16] = '{
    21'h095c0, 21'h0526a, 21'h02b80, 21'h01664,
    21'h00b5d, 21'h005ba, 21'h002e0, 21'h00171,
    21'h000b8, 21'h0005c, 21'h0002e, 21'h00017,
    21'h0000c, 21'h00006, 21'h00003, 21'h00001
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] value
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [20:0] neg_log, [23:21] zero

  logic [20:0] expected_logs[$];
  int          error_count;
  int          burst_left;
  int          gap_max;
  int          hold_left;
  rx_mode_t    rx_mode;
  logic [15:0] rx_pattern;

  neg_log2_q16_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  function automatic logic [20:0] calc_neg_log(input logic [15:0] value);
    logic [32:0] acc;
    logic [32:0] trial;
    logic [20:0] sum;
    acc = {17'd0, value};
    sum = '0;
    for (int i = 0; i < 4; i++) begin
      trial = acc << (8 >> i);
      if (trial < Q16_ONE) begin
        acc = trial;
        sum = sum + (21'h80000 >> i);
      end
    end
    for (int k = 1; k <= 16; k++) begin
      trial = (acc * ((33'd1 << k) + 33'd1)) >> k;
      if (trial < Q16_ONE) begin
        if (k < 16) begin
          acc = trial;
        end
        sum = sum + FINE_STEP_ADD[k-1];
      end
    end
    if (sum == '0) begin
      sum = 21'd1;
    end
    return sum;
  endfunction

  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom);
      1: v = 16'($urandom) >> $urandom_range(0, 15);
      2: v = 16'hffff - 16'($urandom_range(0, 300));
      default: v = (16'd1 << $urandom_range(0, 15)) + 16'($urandom_range(0, 3)) - 16'd1;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("MISMATCH %s: got 0x%06h, expected 0x%06h at %0t", what, got, want, $time);
    end
    error_count++;
  endtask

  // Sends one beat; when gap_max is above zero, the sender idles between bursts of random length.
  task automatic send_value(input logic [15:0] value);
    int gap;
    @(negedge clk);
    if (burst_left <= 0) begin
      gap = (gap_max > 0) ? $urandom_range(1, gap_max) : 0;
      if (gap > 0) begin
        in_tvalid = 1'b0;
        in_tdata  = 16'($urandom);
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid = 1'b1;
    in_tdata  = value;
    do @(posedge clk); while (!in_tready);
    expected_logs.push_back(calc_neg_log(value));
    burst_left--;
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_logs.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [15:0] values[$];
    values = '{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'h7fff, 16'hfffe,
               16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'h0002, 16'h0004,
               16'h0010, 16'h0100, 16'h1000, 16'h4000, 16'h2000, 16'h0800,
               16'h00ab, 16'hfff0, 16'h0003, 16'hc000, 16'h8001, 16'h1234};
    gap_max = 0;
    rx_mode = RX_ALWAYS;
    foreach (values[i]) send_value(values[i]);
    wait_for_drain();
  endtask

  task automatic test_random_bursts();
    gap_max = 6;
    rx_mode = RX_RANDOM;
    repeat (300) send_value(pick_value());
  endtask

  task automatic test_full_rate();
    gap_max = 0;
    burst_left = 1000;
    rx_mode = RX_ALWAYS;
    repeat (150) send_value(pick_value());
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    gap_max = 0;
    burst_left = 1000;
    rx_mode = RX_ALWAYS;
    @(negedge clk);
    in_tvalid = 1'b0;
    hold_left = 60;
    repeat (60) send_value(pick_value());
    @(negedge clk);
    in_tvalid = 1'b0;
    hold_left = 35;
    repeat (60) send_value(pick_value());
  endtask

  task automatic test_drain_pause();
    gap_max = 3;
    rx_mode = RX_RANDOM;
    repeat (50) send_value(pick_value());
    wait_for_drain();
    repeat (50) send_value(pick_value());
    wait_for_drain();
  endtask

  task automatic test_stall_pattern();
    gap_max = 10;
    rx_mode = RX_PATTERN;
    repeat (150) send_value(pick_value());
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_tready = 1'b1;
        RX_RANDOM: out_tready = ($urandom_range(0, 99) < 65);
        default: begin
          out_tready = rx_pattern[0];
          rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin
    logic [20:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_logs.size() == 0) begin
        report_mismatch("beat with nothing expected", out_tdata, 24'd0);
      end else begin
        want = expected_logs.pop_front();
        if (out_tdata[20:0] !== want) begin
          report_mismatch("neg_log", {3'd0, out_tdata[20:0]}, {3'd0, want});
        end
        if (out_tdata[23:21] !== 3'd0) begin
          report_mismatch("padding", out_tdata, {3'd0, want});
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    error_count = 0;
    burst_left  = 0;
    gap_max     = 0;
    hold_left   = 0;
    rx_mode     = RX_ALWAYS;
    rx_pattern  = 16'b1101_0011_1011_0001;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_bursts();
    test_full_rate();
    test_backpressure();
    test_drain_pause();
    test_stall_pattern();

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_logs.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
